// ===== rtl/core/mrdq_pkg.sv =====
`default_nettype none

package mrdq_pkg;

  // default sizes
  localparam int DEPTH_DEF     = 64;
  localparam int MSG_WIDTH_DEF = 32;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int MSG_IO_W = 32;
  localparam int FILL_W   = 7;
  localparam int CAP_IO_W = 7;
  localparam int CAP_RST  = 64;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_CAPACITY = 1'b0;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_SEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_JAM  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RECV = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/message_ring_deque_unit.sv =====
`default_nettype none

// Circular message queue with send-to-tail, jam-to-head and receive-from-head
// actions, one result per transaction. The result of an accepted input
// transaction passes through the pending result stage into the output
// register: the message memory is read or written at acceptance, and its
// registered read data is picked up when the result moves on. One pending
// result stage sits between the memory and the output register, so the
// block sustains one transaction per cycle while results are being taken,
// and still takes one more transaction while a result waits at the output.
// Writing the capacity register (byte address 0) flushes the queue, using only
// the low seven bits; a value of 0 acts as 1 and a value above DEPTH acts as
// DEPTH. Stored words are not cleared at reset, so there is no start-up sweep.
module message_ring_deque_unit #(
  parameter int DEPTH     = mrdq_pkg::DEPTH_DEF,
  parameter int MSG_WIDTH = mrdq_pkg::MSG_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mrdq_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [mrdq_pkg::PDATA_W-1:0]      pwdata,
  output logic      [mrdq_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [mrdq_pkg::ACTION_W-1:0]     action,
  input  wire logic [mrdq_pkg::MSG_IO_W-1:0]     message,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [mrdq_pkg::STATUS_W-1:0]     status,
  output logic      [mrdq_pkg::MSG_IO_W-1:0]     message_out,
  output logic      [mrdq_pkg::FILL_W-1:0]       fill_level
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int EXT_W  = (CNT_W > mrdq_pkg::CAP_IO_W) ? CNT_W : mrdq_pkg::CAP_IO_W;
  localparam int MW_EXT = (MSG_WIDTH > mrdq_pkg::MSG_IO_W) ? MSG_WIDTH : mrdq_pkg::MSG_IO_W;
  localparam int CAP_R  = (mrdq_pkg::CAP_RST > DEPTH) ? DEPTH : mrdq_pkg::CAP_RST;

  // queue state
  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;

  // pending result stage
  logic                          pend_valid;
  logic [mrdq_pkg::STATUS_W-1:0] pend_status;
  logic [CNT_W-1:0]              pend_fill;
  logic                          pend_rd;

  logic                 accept;
  logic                 move;
  logic                 cfg_wr;
  logic                 is_full;
  logic                 is_empty;
  logic                 ram_we;
  logic                 ram_re;
  logic [IDX_W-1:0]     slot;
  logic [CNT_W:0]       tail_sum;
  logic [CNT_W:0]       tail_wrap;
  logic [CNT_W-1:0]     head_inc;
  logic [MSG_WIDTH-1:0] ram_wdata;
  logic [MSG_WIDTH-1:0] ram_rdata;
  logic [mrdq_pkg::STATUS_W-1:0] st_now;
  logic [mrdq_pkg::CAP_IO_W-1:0] cap_in;
  logic [EXT_W-1:0]     cap_clamped;

  // configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == mrdq_pkg::REG_CAPACITY);
  assign cap_in = pwdata[mrdq_pkg::CAP_IO_W-1:0];

  always_comb begin
    if (cap_in == '0) begin
      cap_clamped = EXT_W'(1);
    end else if (EXT_W'(cap_in) > EXT_W'(DEPTH)) begin
      cap_clamped = EXT_W'(DEPTH);
    end else begin
      cap_clamped = EXT_W'(cap_in);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mrdq_pkg::REG_CAPACITY) begin
      prdata = mrdq_pkg::PDATA_W'(capacity);
    end
  end

  // handshake
  assign move     = pend_valid && (!out_valid || out_ready);
  assign in_ready = !pend_valid || move;
  assign accept   = in_valid && in_ready;

  assign is_full  = (count >= capacity);
  assign is_empty = (count == '0);

  // tail slot and head steps, each wrapped at the capacity
  assign tail_sum  = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
  assign tail_wrap = (tail_sum >= (CNT_W + 1)'(capacity)) ?
                     tail_sum - (CNT_W + 1)'(capacity) : tail_sum;
  assign head_inc  = CNT_W'(head) + CNT_W'(1);

  // action decode
  always_comb begin
    slot       = head;
    head_next  = head;
    count_next = count;
    st_now     = mrdq_pkg::ST_DONE;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (action)
      mrdq_pkg::ACT_SEND: begin
        if (is_full) begin
          st_now = mrdq_pkg::ST_FULL;
        end else begin
          slot       = IDX_W'(tail_wrap);
          ram_we     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      mrdq_pkg::ACT_JAM: begin
        if (is_full) begin
          st_now = mrdq_pkg::ST_FULL;
        end else begin
          head_next  = (head == '0) ? IDX_W'(capacity - CNT_W'(1)) : head - IDX_W'(1);
          slot       = head_next;
          ram_we     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      mrdq_pkg::ACT_RECV: begin
        if (is_empty) begin
          st_now = mrdq_pkg::ST_EMPTY;
        end else begin
          ram_re     = 1'b1;
          head_next  = (head_inc >= capacity) ? '0 : IDX_W'(head_inc);
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_wdata = MSG_WIDTH'(MW_EXT'(message));

  mrdq_ram #(
    .WIDTH (MSG_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .re    (accept && ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // capacity, head and count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(CAP_R);
      head     <= '0;
      count    <= '0;
    end else if (cfg_wr) begin
      capacity <= CNT_W'(cap_clamped);
      head     <= '0;
      count    <= '0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // pending result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= st_now;
      pend_fill   <= count_next;
      pend_rd     <= ram_re;
    end
  end

  // output register, read data is stable while the stage is occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      status      <= pend_status;
      fill_level  <= mrdq_pkg::FILL_W'(EXT_W'(pend_fill));
      message_out <= pend_rd ? mrdq_pkg::MSG_IO_W'(MW_EXT'(ram_rdata)) : '0;
    end
  end

  // checks
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= capacity)
    else $error("queued count above capacity");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(head) < capacity)
    else $error("head index outside capacity");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> pend_valid)
    else $error("accepted transaction lost before pending stage");

endmodule

`default_nettype wire

// ===== rtl/core/mrdq_ram.sv =====
`default_nettype none

module mrdq_ram #(
  parameter int WIDTH = mrdq_pkg::MSG_WIDTH_DEF,
  parameter int DEPTH = mrdq_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/message_ring_deque_checker.sv =====
`timescale 1ns / 1ps

module message_ring_deque_checker #(
  parameter int                            DEPTH      = mrdq_pkg::DEPTH_DEF,
  parameter logic [mrdq_pkg::PADDR_W-1:0]  CAP_ADDR   = '0
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mrdq_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [mrdq_pkg::PDATA_W-1:0]    pwdata,
  input  wire logic                            pready,
  // input channel
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [mrdq_pkg::ACTION_W-1:0]   action,
  input  wire logic [mrdq_pkg::MSG_IO_W-1:0]   message,
  // output channel
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [mrdq_pkg::STATUS_W-1:0]   status,
  input  wire logic [mrdq_pkg::MSG_IO_W-1:0]   message_out,
  input  wire logic [mrdq_pkg::FILL_W-1:0]     fill_level,
  // verdict inputs for the testbench top
  output int                                   fail_count,
  output int                                   pending_count
);

  import mrdq_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MSG_IO_W-1:0] word;
    logic [FILL_W-1:0]   fill;
  } deque_result_t;

  // shadow copy of the ring
  logic [MSG_IO_W-1:0] ring_words [DEPTH];
  int unsigned         ring_head;
  int unsigned         ring_count;
  int unsigned         ring_capacity;

  // results still owed by the block, oldest first
  deque_result_t       expected_results [$];

  int                  mismatches = 0;
  int                  waiting    = 0;

  assign fail_count    = mismatches;
  assign pending_count = waiting;

  // capacity register value as the block uses it
  function automatic int unsigned effective_capacity(logic [CAP_IO_W-1:0] value);
    if (value == 0) begin
      return 1;
    end
    if (value > DEPTH) begin
      return DEPTH;
    end
    return value;
  endfunction

  // apply one queue action to the shadow ring and return its result
  function automatic deque_result_t apply_action(logic [ACTION_W-1:0] act,
                                                 logic [MSG_IO_W-1:0] msg);
    deque_result_t r;
    int unsigned   slot;
    r.status = ST_DONE;
    r.word   = '0;
    case (act)
      ACT_SEND, ACT_JAM: begin
        if (ring_count >= ring_capacity) begin
          r.status = ST_FULL;
        end else begin
          if (act == ACT_SEND) begin
            slot = ring_head + ring_count;
            if (slot >= ring_capacity) begin
              slot -= ring_capacity;
            end
          end else begin
            // jam steps the head back, wrapping to the top slot
            ring_head = (ring_head == 0) ? ring_capacity - 1 : ring_head - 1;
            slot      = ring_head;
          end
          ring_words[slot] = msg;
          ring_count++;
        end
      end
      ACT_RECV: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word    = ring_words[ring_head];
          ring_head = (ring_head + 1 >= ring_capacity) ? 0 : ring_head + 1;
          ring_count--;
        end
      end
      default: begin
        // unused action code leaves the ring alone
      end
    endcase
    r.fill = FILL_W'(ring_count);
    return r;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    mismatches++;
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
             $time, field, want_v, got_v);
  endtask

  // monitor both channels and the register port
  always @(posedge clk) begin : monitor
    deque_result_t want;
    if (rst) begin
      ring_head     = 0;
      ring_count    = 0;
      ring_capacity = effective_capacity(CAP_IO_W'(CAP_RST));
      expected_results.delete();
    end else begin
      // compare an output transaction with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual status %0d, %s 0x%08h, %s %0d",
                   $time, status, "message_out", message_out, "fill_level", fill_level);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            report_field("status", 32'(want.status), 32'(status));
          end
          if (message_out !== want.word) begin
            report_field("message_out", want.word, message_out);
          end
          if (fill_level !== want.fill) begin
            report_field("fill_level", 32'(want.fill), 32'(fill_level));
          end
        end
      end
      // capacity write flushes the ring
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        ring_capacity = effective_capacity(pwdata[CAP_IO_W-1:0]);
        ring_head     = 0;
        ring_count    = 0;
      end
      // predict each input transaction
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_action(action, message));
      end
    end
    waiting = expected_results.size();
  end

endmodule

// ===== tb/sv/message_ring_deque_unit_tb.sv =====
`timescale 1ns / 1ps

module message_ring_deque_unit_tb;

  import mrdq_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;
  localparam logic [PADDR_W-1:0]  CAP_ADDR  = PADDR_W'(4 * REG_CAPACITY);
  localparam int                  LONG_HOLD = 250;
  localparam int                  MIX_EVEN  = 0;
  localparam int                  MIX_FILL  = 1;
  localparam int                  MIX_DRAIN = 2;
  localparam int                  PHASES    = 10;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [ACTION_W-1:0] action;
  logic [MSG_IO_W-1:0] message;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [MSG_IO_W-1:0] message_out;
  logic [FILL_W-1:0]   fill_level;

  int                  fail_count;
  int                  pending_count;
  bit                  no_idle;
  int                  hold_requests;

  message_ring_deque_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .message     (message),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .message_out (message_out),
    .fill_level  (fill_level)
  );

  message_ring_deque_checker #(
    .CAP_ADDR (CAP_ADDR)
  ) deque_check (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .message       (message),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .message_out   (message_out),
    .fill_level    (fill_level),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // offer one input transaction, with an occasional idle burst ahead of it
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [MSG_IO_W-1:0] msg);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    message  <= msg;
    do @(posedge clk); while (!in_ready);
  endtask

  // let all results drain, then write the capacity register
  task automatic write_capacity(input logic [PDATA_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result receiver: random stall bursts plus long holds on request
  initial begin : result_sink
    int idle_left;
    int hold_left;
    int holds_served;
    idle_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int                  seg_len;
    int                  mix;
    int                  send_pct;
    int                  jam_pct;
    int                  recv_pct;
    int                  roll;
    int                  done_items;
    logic [PDATA_W-1:0]  cap_word;
    logic [ACTION_W-1:0] act;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    action        = ACT_SEND;
    message       = '0;
    no_idle       = 1'b0;
    hold_requests = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset capacity: empty receive, unused code, head wrap on jam
    send_item(ACT_RECV, 32'h0000_0000);
    send_item(ACT_NONE, 32'hFFFF_FFFF);
    send_item(ACT_SEND, 32'h0000_0000);
    send_item(ACT_SEND, 32'hFFFF_FFFF);
    send_item(ACT_JAM,  32'hA5A5_A5A5);
    send_item(ACT_NONE, 32'h5A5A_5A5A);
    send_item(ACT_RECV, 32'h0000_0000);
    send_item(ACT_RECV, 32'hFFFF_FFFF);
    send_item(ACT_RECV, 32'h0000_0000);
    send_item(ACT_RECV, 32'h0000_0000);

    // zero capacity acts as one slot: full on send and jam
    write_capacity(32'd0);
    send_item(ACT_SEND, 32'h1234_5678);
    send_item(ACT_SEND, 32'h8765_4321);
    send_item(ACT_JAM,  32'hDEAD_BEEF);
    send_item(ACT_RECV, 32'h0000_0000);
    send_item(ACT_JAM,  32'h8000_0001);
    send_item(ACT_RECV, 32'h0000_0000);

    // two slots: jams wrap the head and fill the ring, a send is full until a receive frees a slot
    write_capacity(32'd2);
    send_item(ACT_JAM,  32'h0000_0001);
    send_item(ACT_JAM,  32'h0000_0002);
    send_item(ACT_SEND, 32'h0000_0009);
    send_item(ACT_RECV, 32'h0000_0000);
    send_item(ACT_SEND, 32'h0000_0003);
    send_item(ACT_RECV, 32'h0000_0000);
    send_item(ACT_RECV, 32'h0000_0000);
    send_item(ACT_RECV, 32'h0000_0000);

    // random phases over a range of capacities and action mixes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cap_word = 32'd100; mix = MIX_FILL; seg_len = 120; end
        1: begin cap_word = 32'd1; mix = MIX_EVEN; seg_len = 60; end
        2: begin cap_word = 32'd2; mix = MIX_EVEN; seg_len = 60; end
        3: begin cap_word = 32'd3; mix = MIX_FILL; seg_len = 60; end
        4: begin cap_word = $urandom() & ~32'h7F; mix = MIX_DRAIN; seg_len = 40; end
        5: begin cap_word = $urandom_range(4, 63); mix = MIX_EVEN; seg_len = 80; end
        6: begin cap_word = ($urandom() & ~32'h7F) | 32'd127; mix = MIX_FILL; seg_len = 120; end
        7: begin cap_word = $urandom_range(1, 64); mix = MIX_DRAIN; seg_len = 60; end
        8: begin cap_word = 32'd64; mix = MIX_EVEN; seg_len = 80; end
        default: begin
          cap_word = ($urandom() & ~32'h7F) | $urandom_range(1, 64);
          mix      = MIX_FILL;
          seg_len  = 70;
        end
      endcase
      case (mix)
        MIX_FILL:  begin send_pct = 55; jam_pct = 35; recv_pct = 8; end
        MIX_DRAIN: begin send_pct = 20; jam_pct = 15; recv_pct = 62; end
        default:   begin send_pct = 40; jam_pct = 20; recv_pct = 37; end
      endcase
      if (p >= PHASES - 2) begin
        no_idle = 1'b1;
      end
      write_capacity(cap_word);
      // long receiver hold while input keeps coming
      if (p == 0) begin
        hold_requests++;
      end
      done_items = 0;
      while (done_items < seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < send_pct) begin
          act = ACT_SEND;
        end else if (roll < send_pct + jam_pct) begin
          act = ACT_JAM;
        end else if (roll < send_pct + jam_pct + recv_pct) begin
          act = ACT_RECV;
        end else begin
          act = ACT_NONE;
        end
        send_item(act, $urandom());
        if (act != ACT_NONE) begin
          done_items++;
        end
      end
    end

    // drain and give the verdict
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mrdq_pkg.sv
rtl/core/mrdq_ram.sv
rtl/core/message_ring_deque_unit.sv
tb/sv/message_ring_deque_checker.sv
tb/sv/message_ring_deque_unit_tb.sv
